// ===== rtl/b64d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the alphabet decode function of the base64 stream
// decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Special characters of the alphabet
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LO_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_DIG_0 = 8'h30;  // '0'
  localparam logic [7:0] CHAR_DIG_9 = 8'h39;  // '9'

  // Sextet offsets for lower case letters and digits, and the sextets of plus and slash
  localparam logic [5:0] SX_LO_BASE  = 6'd26;
  localparam logic [5:0] SX_DIG_BASE = 6'd52;
  localparam logic [5:0] SX_PLUS     = 6'd62;
  localparam logic [5:0] SX_SLASH    = 6'd63;

  // Command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_CHAR   = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  // Input transaction
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_final;
  } item_t;

  // Output transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    status_t    status;
    logic       run_last;
    logic       message_end;
  } result_t;

  // One decoded group handed from front to back.
  // nbytes of zero marks an incomplete final group.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        bad;
    logic        fin;
  } cmd_t;

  // Alphabet lookup result
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  function automatic sextet_t map_char(input logic [7:0] c);
    sextet_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      d = c - CHAR_UP_A;
      r.ok = 1'b1;
      r.val = d[5:0];
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      d = c - CHAR_LO_A;
      r.ok = 1'b1;
      r.val = d[5:0] + SX_LO_BASE;
    end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
      d = c - CHAR_DIG_0;
      r.ok = 1'b1;
      r.val = d[5:0] + SX_DIG_BASE;
    end else if (c == CHAR_PLUS) begin
      r.ok = 1'b1;
      r.val = SX_PLUS;
    end else if (c == CHAR_SLASH) begin
      r.ok = 1'b1;
      r.val = SX_SLASH;
    end else if (c == CHAR_PAD) begin
      r.ok = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/b64d_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, decodes them through the alphabet and collects groups
// of four; each complete group or early final mark becomes one command.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output logic  cmd_push,
  output cmd_t  cmd,
  input  logic  cmd_full
);

  logic [1:0]  pos;
  logic [1:0]  pos_next;
  logic [17:0] acc;
  logic [17:0] acc_next;
  logic        bad;
  logic        bad_next;
  logic        third_pad;
  logic        third_pad_next;
  logic        accept;
  logic        is_pad;
  logic        bad_now;
  logic [1:0]  drop;
  sextet_t     sx;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;
  assign sx     = map_char(item.char_code);
  assign is_pad = (item.char_code == CHAR_PAD);
  assign bad_now = bad || !sx.ok;

  // Classify the transaction and build the group command
  always_comb begin
    pos_next       = pos;
    acc_next       = acc;
    bad_next       = bad;
    third_pad_next = third_pad;
    cmd_push       = 1'b0;
    cmd.word       = {acc, sx.val};
    cmd.nbytes     = 2'd3;
    cmd.bad        = bad_now;
    cmd.fin        = item.is_final;
    drop           = {1'b0, item.is_final && third_pad} + {1'b0, item.is_final && is_pad};
    if (accept) begin
      if (pos != 2'd3) begin
        if (item.is_final) begin
          // Early final mark: report incomplete group, drop collected sextets
          cmd_push       = 1'b1;
          cmd.nbytes     = 2'd0;
          pos_next       = 2'd0;
          acc_next       = '0;
          bad_next       = 1'b0;
          third_pad_next = 1'b0;
        end else begin
          if (pos == 2'd2) begin
            third_pad_next = is_pad;
          end
          acc_next = {acc[11:0], sx.val};
          bad_next = bad_now;
          pos_next = pos + 2'd1;
        end
      end else begin
        // Fourth character: group complete
        cmd_push       = 1'b1;
        cmd.nbytes     = 2'd3 - drop;
        pos_next       = 2'd0;
        acc_next       = '0;
        bad_next       = 1'b0;
        third_pad_next = 1'b0;
      end
    end
  end

  // Hold group state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      acc       <= '0;
      bad       <= 1'b0;
      third_pad <= 1'b0;
    end else begin
      pos       <= pos_next;
      acc       <= acc_next;
      bad       <= bad_next;
      third_pad <= third_pad_next;
    end
  end

  a_final_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && item.is_final) |=> (pos == 2'd0 && !bad && !third_pad))
    else $error("group state not cleared after final character");

  a_cmd_on_fourth: assert property (@(posedge clk) disable iff (rst)
    (accept && pos == 2'd3) |-> (cmd_push && cmd.nbytes != 2'd0))
    else $error("complete group produced no byte command");

endmodule

// ===== rtl/b64d_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_cmd_fifo
// Short first-in first-out queue of group commands between front and back.
// ----------------------------------------------------------------------------
module b64d_cmd_fifo
  import b64d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t                 slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = (count == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CMD_CNT_W'(CMD_DEPTH))
    else $error("command queue occupancy out of range");

  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    do_wr |=> !empty)
    else $error("command queue empty right after a write");

endmodule

// ===== rtl/b64d_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Takes group commands from the queue and emits their results one per
// cycle while pop is high, high byte first.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  logic    cmd_empty,
  output logic    cmd_pop,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] k;
  logic       last;
  logic       fire;
  logic       load;

  assign empty   = !cur_valid;
  assign fire    = pop && cur_valid;
  assign last    = (cur.nbytes == 2'd0) || (k == cur.nbytes - 2'd1);
  assign load    = !cur_valid || (fire && last);
  assign cmd_pop = load && !cmd_empty;

  // Form the current result
  always_comb begin
    result.byte_valid  = 1'b1;
    result.status      = cur.bad ? ST_BAD_CHAR : ST_OK;
    result.run_last    = last;
    result.message_end = last && cur.fin;
    case (k)
      2'd0:    result.data_byte = cur.word[23:16];
      2'd1:    result.data_byte = cur.word[15:8];
      2'd2:    result.data_byte = cur.word[7:0];
      default: result.data_byte = '0;
    endcase
    if (cur.nbytes == 2'd0) begin
      result.byte_valid = 1'b0;
      result.data_byte  = '0;
      result.status     = ST_INCOMPLETE;
    end
  end

  // Hold the current command payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  // Advance through the bytes of the current command
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k         <= '0;
    end else if (load) begin
      cur_valid <= !cmd_empty;
      k         <= '0;
    end else if (fire) begin
      k <= k + 2'd1;
    end
  end

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.nbytes != 2'd0) |-> (k < cur.nbytes))
    else $error("byte index beyond command length");

endmodule

// ===== rtl/base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Decodes a base64 character stream into bytes with group status.
//
// Input channel: item (char_code, is_final) is taken at a clock edge with
// push high and full low. Output channel: result is the oldest waiting
// result while empty is low and is taken at an edge with pop high.
// Each group of four characters yields up to three byte results, high byte
// first; a final mark before the fourth character yields one result with
// status incomplete and no byte. An invalid character reads as zero and
// flags its group.
// With the back end idle, a group's command enters the queue at the edge taking
// the character that completes it; the back end then loads it and shows its
// first result. Throughput: one character per cycle while full is low; the
// back end emits one result per cycle while pop is high, so three bytes per
// four characters keep pace.
// A four-entry command queue separates front and back; when the receiver
// stalls, the queue fills and full rises, and nothing is lost.
// Reset (rst, synchronous) clears the group state and empties the queue.
// ----------------------------------------------------------------------------
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_in;
  cmd_t cmd_out;

  // Classify characters into group commands
  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  // Decouple front and back
  b64d_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // Emit results
  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== tb/base64_stream_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_test
// Self-checking bench for the base64 stream decoder. Characters go in through
// the push/full side, decoded bytes come out through the empty/pop side. A
// small tracker class decodes every accepted character on its own and keeps
// the bytes it expects; each popped result is compared field by field with
// the oldest one. A directed opening covers alphabet extremes, padding,
// bad characters and short final groups; random messages follow, mostly
// well formed, some broken, some pure noise, under random idling on both
// sides.
// ----------------------------------------------------------------------------
module base64_stream_decoder_test;
  import b64d_pkg::*;

  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int RANDOM_CHARS = 400;

  // Independent decoder: tracks group state and holds the bytes it expects
  class b64_tracker;
    logic [1:0]  grp_pos;
    logic [17:0] sextets;
    bit          bad_in_grp;
    bit          pad_third;
    result_t     decoded_q[$];
    int          errors;
    int          checked;
    int          flagged;
    int          incompletes;

    function new();
      clear_group();
    endfunction

    function void clear_group();
      grp_pos    = 2'd0;
      sextets    = '0;
      bad_in_grp = 1'b0;
      pad_third  = 1'b0;
    endfunction

    // Return {valid, sextet}; the pad character reads as a valid zero
    function logic [6:0] lookup(logic [7:0] c);
      logic [6:0] hit;
      hit = 7'd0;
      if (c == CHAR_PAD) begin
        hit = 7'h40;
      end
      for (int i = 0; i < 64; i++) begin
        if (B64_ALPHABET[i] == c) begin
          hit = {1'b1, 6'(i)};
        end
      end
      return hit;
    endfunction

    function void add_result(logic [7:0] b, logic vld, status_t st, logic last,
                             logic msg_end);
      result_t r;
      r.data_byte   = b;
      r.byte_valid  = vld;
      r.status      = st;
      r.run_last    = last;
      r.message_end = msg_end;
      decoded_q.push_back(r);
    endfunction

    // Decode one accepted character and queue whatever it produces
    function void take_char(item_t it);
      logic [6:0]  m;
      logic [5:0]  sx;
      logic [23:0] word;
      bit          pad;
      int          n;
      status_t     st;
      m   = lookup(it.char_code);
      sx  = m[5:0];
      pad = (it.char_code == CHAR_PAD);
      if (!m[6]) begin
        bad_in_grp = 1'b1;
      end
      if (grp_pos != 2'd3) begin
        if (grp_pos == 2'd2) begin
          pad_third = pad;
        end
        sextets = {sextets[11:0], sx};
        // final mark inside a group: one flagged result, group dropped
        if (it.is_final) begin
          add_result(8'h00, 1'b0, ST_INCOMPLETE, 1'b1, 1'b1);
          clear_group();
        end else begin
          grp_pos++;
        end
      end else begin
        word = {sextets, sx};
        st   = bad_in_grp ? ST_BAD_CHAR : ST_OK;
        n    = 3;
        // trailing pads trim bytes only on the final group
        if (it.is_final) begin
          n = n - int'(pad_third) - int'(pad);
        end
        for (int k = 0; k < n; k++) begin
          add_result(word[23 - 8 * k -: 8], 1'b1, st, k == n - 1,
                     (k == n - 1) && it.is_final);
        end
        clear_group();
      end
    endfunction

    // Compare one popped result with the oldest expected one
    function void check_out(result_t got);
      result_t want;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte=%02h valid=%0b status=%0d last=%0b end=%0b",
                 $time, got.data_byte, got.byte_valid, got.status, got.run_last,
                 got.message_end);
        return;
      end
      want = decoded_q.pop_front();
      checked++;
      if (want.status == ST_BAD_CHAR) flagged++;
      if (want.status == ST_INCOMPLETE) incompletes++;
      if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
          got.status !== want.status || got.run_last !== want.run_last ||
          got.message_end !== want.message_end) begin
        errors++;
        $display("%0t: mismatch expected byte=%02h valid=%0b status=%0d last=%0b end=%0b",
                 $time, want.data_byte, want.byte_valid, want.status, want.run_last,
                 want.message_end);
        $display("%0t:          actual   byte=%02h valid=%0b status=%0d last=%0b end=%0b",
                 $time, got.data_byte, got.byte_valid, got.status, got.run_last,
                 got.message_end);
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;

  b64_tracker  trk;
  bit          calm_mode;
  logic [7:0]  msg_buf[$];
  int          chars_sent;
  int          msgs_sent;

  base64_stream_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none, some short, a few long; none in calm stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one character and hold it until the transaction completes
  task automatic send_char(input logic [7:0] c, input logic fin);
    int    g;
    item_t it;
    g = idle_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    it.char_code = c;
    it.is_final  = fin;
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    trk.take_char(it);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], fin && (i == s.len() - 1));
    end
  endtask

  task automatic send_msg();
    foreach (msg_buf[i]) begin
      send_char(msg_buf[i], i == msg_buf.size() - 1);
    end
    msgs_sent++;
  endtask

  // Hold off the sender until every expected result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (trk.decoded_q.size() != 0) @(posedge clk);
  endtask

  // Build one random message: mostly well formed, the rest broken or noise
  task automatic build_msg();
    int groups;
    int pads;
    int style;
    int len;
    msg_buf.delete();
    style = $urandom_range(0, 99);
    if (style >= 94) begin
      len = $urandom_range(1, 9);
      repeat (len) msg_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    pads   = $urandom_range(0, 2);
    repeat (groups * 4 + 4 - pads) begin
      msg_buf.push_back(B64_ALPHABET[$urandom_range(0, 63)]);
    end
    repeat (pads) msg_buf.push_back(CHAR_PAD);
    if (style >= 70 && style < 80) begin
      // corrupt one character with any byte value
      msg_buf[$urandom_range(0, msg_buf.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (style >= 80 && style < 88) begin
      // cut the tail so the final group ends early
      repeat ($urandom_range(1, 3)) void'(msg_buf.pop_back());
    end else if (style >= 88) begin
      // drop a pad somewhere it does not belong
      msg_buf[$urandom_range(0, msg_buf.size() - 1)] = CHAR_PAD;
    end
  endtask

  // Result side: check every popped transaction, stall at random
  initial begin
    int stall_left;
    stall_left = 0;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        trk.check_out(result);
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int  random_chars;
    bit  paused_once;
    trk          = new();
    calm_mode    = 1'b0;
    chars_sent   = 0;
    msgs_sent    = 0;
    random_chars = 0;
    paused_once  = 1'b0;
    rst  <= 1'b1;
    push <= 1'b0;
    item <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: alphabet extremes, padding, bad characters, short finals
    send_text("////", 1'b0);
    send_text("Za09", 1'b1);
    send_text("QQ==", 1'b0);
    send_text("QUI=", 1'b1);
    send_text("QQ=A", 1'b1);
    send_char("Q", 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("==", 1'b1);
    send_char(8'h80, 1'b1);
    send_text("QU", 1'b0);
    send_char(8'h00, 1'b1);
    send_text("+/9z", 1'b0);
    wait_drained();

    // Random messages, calm now and then, one full drain midway and more at random
    while (random_chars < RANDOM_CHARS) begin
      calm_mode = ($urandom_range(0, 9) == 0);
      build_msg();
      send_msg();
      random_chars += msg_buf.size();
      if ((!paused_once && random_chars >= RANDOM_CHARS / 2) ||
          $urandom_range(0, 19) == 0) begin
        wait_drained();
        paused_once = 1'b1;
      end
    end

    // Drain, then watch a while longer for stray results
    wait_drained();
    calm_mode = 1'b1;
    repeat (20) @(posedge clk);

    if (trk.decoded_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, trk.decoded_q.size());
    end
    $display("Sent %0d characters in %0d messages plus directed groups.",
             chars_sent, msgs_sent);
    $display("Checked %0d results: %0d with a bad character, %0d incomplete finals.",
             trk.checked, trk.flagged, trk.incompletes);
    if (trk.errors == 0 && trk.decoded_q.size() == 0) begin
      $display("PASS base64_stream_decoder");
    end else begin
      $display("FAIL base64_stream_decoder");
    end
    $finish;
  end

  // Watchdog: generous bound on the slowest correct run
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("FAIL base64_stream_decoder");
    $finish;
  end

endmodule
